// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W           = 20;
  localparam int SIZE_W           = 16;
  localparam int STATUS_W         = 3;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 20'd65536;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_MEMORY = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NULL      = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  // one table entry as stored in the block table ram
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

  // finished result handed from the controller to the output register
  typedef struct packed {
    logic              vld;
    status_t           status;
    logic [ADDR_W-1:0] paddr;
  } res_t;

endpackage

// ===== sv/ffba_if.sv =====
// ----------------------------------------------------------------------------
// ffba channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_in_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, command, request_size, block_address, input ready);
  modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface ffba_out_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   payload_address;

  modport source (output valid, status, payload_address, input ready);
  modport sink   (input valid, status, payload_address, output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] heap_limit;

  modport source (output valid, heap_limit, input ready);
  modport sink   (input valid, heap_limit, output ready);
endinterface

// ===== sv/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: scans the block table one entry per cycle, then
// updates the hit entry, appends a new block at the heap top, or reports a miss.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ffba_in_if.sink                   in_chan,
  input  logic [ADDR_W-1:0]         heap_limit,
  output res_t                      res,
  input  logic                      res_rdy,
  output logic                      ram_rd_en,
  output logic [IDX_W-1:0]          ram_rd_addr,
  input  logic [$bits(entry_t)-1:0] ram_rd_data,
  output logic                      ram_wr_en,
  output logic [IDX_W-1:0]          ram_wr_addr,
  output logic [$bits(entry_t)-1:0] ram_wr_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int END_W = ADDR_W + 1;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] top_r, top_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;

  entry_t            ent, wr_ent;
  logic [END_W-1:0]  ent_paddr_full;
  logic [END_W-1:0]  new_end;
  logic              alloc_hit, rel_hit, hit, scan_done, table_full, fits;
  logic              in_fire, null_req;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign null_req = (cmd_t'(in_chan.command) == CMD_RELEASE) &&
                    (in_chan.block_address == '0);

  assign ent            = entry_t'(ram_rd_data);
  assign ent_paddr_full = {1'b0, ent.start} + END_W'(HEADER_BYTES);
  assign alloc_hit      = ent.is_free && (ent.size >= req_r);
  assign rel_hit        = ent_paddr_full == {1'b0, addr_r};
  assign hit            = pend_r && ((cmd_r == CMD_RELEASE) ? rel_hit : alloc_hit);
  assign scan_done      = !pend_r && (rd_idx_r >= count_r);
  assign new_end        = {1'b0, top_r} + END_W'(HEADER_BYTES) + END_W'(req_r);
  assign table_full     = count_r >= CNT_W'(MAX_BLOCKS);
  assign fits           = new_end <= {1'b0, heap_limit};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = null_req ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_chan.ready = 1'b0;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    paddr_nxt     = paddr_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = rd_idx_r[IDX_W-1:0];
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cmp_idx_r;
    wr_ent        = ent;
    res.vld       = 1'b0;
    res.status    = status_r;
    res.paddr     = paddr_r;

    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_fire) begin
          cmd_nxt    = cmd_t'(in_chan.command);
          req_nxt    = in_chan.request_size;
          addr_nxt   = in_chan.block_address;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          status_nxt = ST_NULL;
          paddr_nxt  = '0;
        end
      end
      S_SCAN: begin
        // keep one read in flight ahead of the compare
        if (rd_idx_r < count_r) begin
          ram_rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        priority if (hit) begin
          ram_wr_en      = 1'b1;
          ram_wr_addr    = cmp_idx_r;
          wr_ent.is_free = (cmd_r == CMD_RELEASE);
          if (cmd_r == CMD_RELEASE) begin
            status_nxt = ST_RELEASED;
            paddr_nxt  = '0;
          end else begin
            status_nxt = ST_ALLOCATED;
            paddr_nxt  = ent_paddr_full[ADDR_W-1:0];
          end
        end else if (scan_done) begin
          paddr_nxt = '0;
          if (cmd_r == CMD_RELEASE) begin
            status_nxt = ST_UNKNOWN;
          end else if (table_full || !fits) begin
            status_nxt = ST_NO_MEMORY;
          end else begin
            // append a fresh block at the heap top
            ram_wr_en      = 1'b1;
            ram_wr_addr    = count_r[IDX_W-1:0];
            wr_ent.start   = top_r;
            wr_ent.size    = req_r;
            wr_ent.is_free = 1'b0;
            count_nxt      = count_r + CNT_W'(1);
            top_nxt        = new_end[ADDR_W-1:0];
            status_nxt     = ST_ALLOCATED;
            paddr_nxt      = top_r + ADDR_W'(HEADER_BYTES);
          end
        end
      end
      S_RESULT: begin
        res.vld = 1'b1;
      end
      default: begin
        res.vld = 1'b0;
      end
    endcase
  end

  assign ram_wr_data = wr_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    paddr_r   <= paddr_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_SCAN))
    else $error("table write outside scan");

  a_null_release: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && null_req) |=> (state_r == S_RESULT && status_r == ST_NULL))
    else $error("null release not answered directly");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && !res_rdy) |=>
      (state_r == S_RESULT && $stable(paddr_r) && $stable(status_r)))
    else $error("pending result lost");
`endif

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
// scan: the table ram is read one entry per cycle until a hit or the end
// of the table.
// requests: one at a time; the next is taken once the result has moved
// into the output register.
// reset: block count, heap top and output valid clear, heap_limit returns to
// 65536; the block table needs no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap block allocator with an address-ordered block table in ram.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ffba_in_if.sink     in_chan,
  ffba_out_if.source  out_chan,
  ffba_cfg_if.sink    cfg_chan
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int ENT_W = $bits(entry_t);

  logic [ADDR_W-1:0]   heap_limit_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_paddr_r;

  res_t                res;
  logic                res_rdy;
  logic                ram_rd_en, ram_wr_en;
  logic [IDX_W-1:0]    ram_rd_addr, ram_wr_addr;
  logic [ENT_W-1:0]    ram_rd_data, ram_wr_data;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= HEAP_LIMIT_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      heap_limit_r <= cfg_chan.heap_limit;
    end
  end

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffba_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .heap_limit  (heap_limit_r),
    .res         (res),
    .res_rdy     (res_rdy),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  // output register frees the sequencer while the result waits
  assign res_rdy = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy && res.vld) begin
      out_status_r <= res.status;
      out_paddr_r  <= res.paddr;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.payload_address = out_paddr_r;

endmodule

// ===== tb/first_fit_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_test
// Drives allocate and release requests into the first-fit allocator with
// random gaps on both channels, and checks every result against an in-bench
// model of the block table, heap top and heap limit.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;

  localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
  localparam int HDR_BYTES  = HEADER_BYTES_DEF;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] paddr;
  } grant_t;

  logic clk;
  logic rst_n;

  ffba_in_if  in_chan ();
  ffba_out_if out_chan ();
  ffba_cfg_if cfg_chan ();

  first_fit_block_allocator_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // allocator model state
  logic [ADDR_W-1:0] tbl_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] tbl_size  [MAX_BLOCKS];
  logic              tbl_free  [MAX_BLOCKS];
  int unsigned       tbl_count;
  logic [ADDR_W-1:0] model_top;
  logic [ADDR_W-1:0] model_limit;

  grant_t grant_q[$];
  int     fail_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // first-fit lookup, append at heap top, or release by payload address
  function automatic grant_t predict_request(cmd_t cmd, logic [SIZE_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
    grant_t          g;
    bit              hit;
    longint unsigned end_addr;
    hit     = 1'b0;
    g.paddr = '0;
    if (cmd == CMD_ALLOC) begin
      g.status = ST_NO_MEMORY;
      for (int i = 0; i < tbl_count; i++) begin
        if (!hit && tbl_free[i] && tbl_size[i] >= size) begin
          hit         = 1'b1;
          tbl_free[i] = 1'b0;
          g.status    = ST_ALLOCATED;
          g.paddr     = ADDR_W'(tbl_start[i] + HDR_BYTES);
        end
      end
      if (!hit && tbl_count < MAX_BLOCKS) begin
        end_addr = longint'(model_top) + HDR_BYTES + size;
        if (end_addr <= longint'(model_limit)) begin
          tbl_start[tbl_count] = model_top;
          tbl_size[tbl_count]  = size;
          tbl_free[tbl_count]  = 1'b0;
          tbl_count++;
          g.status  = ST_ALLOCATED;
          g.paddr   = ADDR_W'(model_top + HDR_BYTES);
          model_top = ADDR_W'(end_addr);
        end
      end
    end else if (addr == '0) begin
      g.status = ST_NULL;
    end else begin
      g.status = ST_UNKNOWN;
      for (int i = 0; i < tbl_count; i++) begin
        if (!hit && longint'(tbl_start[i]) + HDR_BYTES == longint'(addr)) begin
          hit         = 1'b1;
          tbl_free[i] = 1'b1;
          g.status    = ST_RELEASED;
        end
      end
    end
    return g;
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return SIZE_W'($urandom_range(0, 63));
    if (r < 75) return SIZE_W'($urandom_range(0, 1023));
    if (r < 87) return SIZE_W'($urandom_range(0, 8191));
    if (r < 95) return SIZE_W'($urandom);
    if (r < 98) return '0;
    return '1;
  endfunction

  // mostly live payload addresses, some null, near misses and noise
  function automatic logic [ADDR_W-1:0] random_release_addr();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = (tbl_count != 0) ? $urandom_range(tbl_count - 1) : 0;
    if (tbl_count != 0 && r < 75) return ADDR_W'(tbl_start[k] + HDR_BYTES);
    if (r < 82) return '0;
    if (tbl_count != 0 && r < 90)
      return ADDR_W'(tbl_start[k] + HDR_BYTES + $urandom_range(1, 15));
    return ADDR_W'($urandom);
  endfunction

  task automatic send_request(cmd_t cmd, logic [SIZE_W-1:0] size,
                              logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid         <= 1'b1;
    in_chan.command       <= cmd;
    in_chan.request_size  <= size;
    in_chan.block_address <= addr;
    do @(posedge clk); while (!in_chan.ready);
    grant_q.push_back(predict_request(cmd, size, addr));
  endtask

  task automatic send_random_request();
    if ($urandom_range(99) < 55) begin
      send_request(CMD_ALLOC, random_size(), ADDR_W'($urandom));
    end else begin
      send_request(CMD_RELEASE, SIZE_W'($urandom), random_release_addr());
    end
  endtask

  // drop valid, then hold off until every result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap_limit(logic [ADDR_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_chan.valid      <= 1'b1;
    cfg_chan.heap_limit <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    model_limit = value;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_request(CMD_ALLOC, 16'd0, '0);          // header-only block
    send_request(CMD_ALLOC, 16'hFFFF, '0);       // heap exhausted
    send_request(CMD_ALLOC, 16'd65504, '1);      // ends exactly at the limit
    send_request(CMD_RELEASE, '1, 20'd0);        // null
    send_request(CMD_RELEASE, '0, 20'hFFFFF);    // unknown
    send_request(CMD_RELEASE, '0, 20'd16);
    send_request(CMD_RELEASE, '0, 20'd16);       // double release
    send_request(CMD_RELEASE, '0, 20'd32);
    send_request(CMD_RELEASE, '0, 20'd15);       // matches no payload address
    send_request(CMD_ALLOC, 16'd0, '0);          // reuses the empty block
    send_request(CMD_ALLOC, 16'd1, '0);          // big block, no split
    send_request(CMD_ALLOC, 16'd1, '0);          // nothing free, no room
  endtask

  task automatic test_limit_extremes();
    write_heap_limit('0);
    send_request(CMD_ALLOC, 16'd0, '0);          // limit below top
    send_request(CMD_RELEASE, '0, 20'd32);
    send_request(CMD_ALLOC, 16'hFFFF, '0);
    write_heap_limit('1);
    send_request(CMD_ALLOC, 16'hFFFF, '0);
    send_request(CMD_ALLOC, 16'd65504, '0);
    send_request(CMD_RELEASE, '0, 20'd65552);
    send_request(CMD_ALLOC, 16'd1000, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct,
                                     logic [ADDR_W-1:0] limit);
    write_heap_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) send_random_request();
    wait_for_results();
  endtask

  // receiver stalls while requests keep coming, then the sender drains
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 300;
    repeat (8) send_random_request();
    wait_for_results();
    repeat (4) send_random_request();
    wait_for_results();
  endtask

  task automatic test_table_full();
    int tries;
    write_heap_limit('1);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    tries = 0;
    while (tbl_count < MAX_BLOCKS && tries < 96) begin
      send_request(CMD_ALLOC, SIZE_W'($urandom_range(0, 15)), '0);
      tries++;
    end
    send_request(CMD_ALLOC, 16'hFFFF, '0);
    send_request(CMD_RELEASE, '0, random_release_addr());
    send_request(CMD_ALLOC, 16'hFFFF, '0);
    send_request(CMD_ALLOC, 16'd0, '0);
    wait_for_results();
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    grant_t exp_grant;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result transaction: status %0d payload_address 'h%05h",
               out_chan.status, out_chan.payload_address);
        fail_count++;
      end else begin
        exp_grant = grant_q.pop_front();
        if (out_chan.status !== exp_grant.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_grant.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.payload_address !== exp_grant.paddr) begin
          $error("payload_address mismatch: expected 'h%05h, actual 'h%05h",
                 exp_grant.paddr, out_chan.payload_address);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.command       = CMD_ALLOC;
    in_chan.request_size  = '0;
    in_chan.block_address = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.heap_limit   = '0;
    out_chan.ready        = 1'b0;
    rst_n                 = 1'b0;
    fail_count            = 0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    hold_left             = 0;
    tbl_count             = 0;
    model_top             = '0;
    model_limit           = HEAP_LIMIT_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_limit_extremes();
    test_random_traffic(150, 7, 56, '1);
    test_output_backpressure();
    test_table_full();
    test_random_traffic(150, 56, 7, ADDR_W'($urandom_range(model_top, 20'hFFFFF)));
    test_random_traffic(150, 0, 0, '1);

    wait_for_results();
    repeat (MAX_BLOCKS + 8) @(posedge clk);
    if (fail_count == 0 && grant_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== first_fit_block_allocator_unit.f =====
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_ram.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_unit.sv
tb/first_fit_block_allocator_unit_test.sv
